@@ rtl/cie_pkg.sv @@
// ----------------------------------------------------------------------------
// cie_pkg: shared definitions for the custom ISA execute unit
// Opcodes, sizes, masks and the execute result record.
// ----------------------------------------------------------------------------
package cie_pkg;

    localparam int WORD_W     = 32;
    localparam int FIELD_W    = 5;
    localparam int ADDR_OUT_W = 11;
    localparam int IMM_W      = 18;
    localparam int SHAMT_W    = 13;

    // Register file size; entry zero always reads as zero.
    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    // Data memory depth in words; must be a power of two.
    localparam int DATA_DEPTH = 2048;
    localparam int DM_AW      = $clog2(DATA_DEPTH);

    localparam logic [WORD_W-1:0]  PC_HI_MASK  = 32'hF000_0000;
    localparam logic [WORD_W-1:0]  JMP_MASK    = 32'h0FFF_FFFF;
    localparam logic [WORD_W-1:0]  DM_MASK     = WORD_W'(DATA_DEPTH - 1);
    localparam logic [SHAMT_W-1:0] SHIFT_LIMIT = SHAMT_W'(WORD_W);

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_MOVI = 4'd3,
        OP_JEQ  = 4'd4,
        OP_AND  = 4'd5,
        OP_XORI = 4'd6,
        OP_JMP  = 4'd7,
        OP_LSL  = 4'd8,
        OP_LSR  = 4'd9,
        OP_MOVR = 4'd10,
        OP_MOVM = 4'd11
    } t_opcode;

    typedef struct packed {
        logic [WORD_W-1:0]  next_pc;
        logic               taken;
        logic               wr;
        logic [FIELD_W-1:0] idx;
        logic [WORD_W-1:0]  val;
        logic               is_load;
        logic               is_store;
        logic [WORD_W-1:0]  mem_addr;
        logic [WORD_W-1:0]  store_val;
    } t_exec_out;

    // True when a register number names a real, writable entry.
    function automatic logic reg_ok(input logic [FIELD_W-1:0] idx);
        reg_ok = (idx != '0) && ({{(WORD_W - FIELD_W){1'b0}}, idx} < WORD_W'(REG_COUNT));
    endfunction

endpackage

@@ rtl/cie_channels.sv @@
// ----------------------------------------------------------------------------
// cie_channels: valid/ready channels of the execute unit
// Instruction channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface cie_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface cie_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        branch_taken;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [10:0] mem_address;
    logic [31:0] mem_value;

    modport source (output valid, output next_pc, output branch_taken, output reg_write,
                    output reg_index, output reg_value, output mem_write,
                    output mem_address, output mem_value, input ready);
    modport sink   (input valid, input next_pc, input branch_taken, input reg_write,
                    input reg_index, input reg_value, input mem_write,
                    input mem_address, input mem_value, output ready);
endinterface

@@ rtl/cie_exec.sv @@
// ----------------------------------------------------------------------------
// cie_exec: instruction decode and execute
// Combinational ALU, branch and address logic for one instruction word.
// ----------------------------------------------------------------------------
module cie_exec import cie_pkg::*; (
    input  logic [WORD_W-1:0] i_word,
    input  logic [WORD_W-1:0] i_r1_val,
    input  logic [WORD_W-1:0] i_r2_val,
    input  logic [WORD_W-1:0] i_r3_val,
    input  logic [WORD_W-1:0] i_pc,
    output t_exec_out         o_exec
);

    t_opcode             op;
    logic [FIELD_W-1:0]  r1;
    logic [WORD_W-1:0]   imm;
    logic [SHAMT_W-1:0]  shamt;
    logic [WORD_W-1:0]   pc_inc;
    logic [WORD_W-1:0]   addr_sum;
    logic [WORD_W-1:0]   product;

    assign op       = t_opcode'(i_word[31:28]);
    assign r1       = i_word[27:23];
    assign imm      = {{(WORD_W - IMM_W){1'b0}}, i_word[IMM_W-1:0]};
    assign shamt    = i_word[SHAMT_W-1:0];
    assign pc_inc   = i_pc + WORD_W'(1);
    assign addr_sum = i_r2_val + imm;
    assign product  = i_r2_val * i_r3_val;

    always_comb begin
        o_exec         = '0;
        o_exec.next_pc = pc_inc;
        case (op)
            OP_ADD: begin
                o_exec.val = i_r2_val + i_r3_val;
                o_exec.wr  = 1'b1;
            end
            OP_SUB: begin
                o_exec.val = i_r2_val - i_r3_val;
                o_exec.wr  = 1'b1;
            end
            OP_MUL: begin
                o_exec.val = product;
                o_exec.wr  = 1'b1;
            end
            OP_MOVI: begin
                o_exec.val = imm;
                o_exec.wr  = 1'b1;
            end
            OP_JEQ: begin
                if (i_r1_val == i_r2_val) begin
                    o_exec.next_pc = pc_inc + imm;
                    o_exec.taken   = 1'b1;
                end
            end
            OP_AND: begin
                o_exec.val = i_r2_val & i_r3_val;
                o_exec.wr  = 1'b1;
            end
            OP_XORI: begin
                o_exec.val = i_r2_val ^ imm;
                o_exec.wr  = 1'b1;
            end
            OP_JMP: begin
                o_exec.next_pc = (pc_inc & PC_HI_MASK) | (i_word & JMP_MASK);
                o_exec.taken   = 1'b1;
            end
            OP_LSL: begin
                o_exec.val = (shamt >= SHIFT_LIMIT) ? '0 : (i_r2_val << shamt[4:0]);
                o_exec.wr  = 1'b1;
            end
            OP_LSR: begin
                o_exec.val = (shamt >= SHIFT_LIMIT) ? '0 : (i_r2_val >> shamt[4:0]);
                o_exec.wr  = 1'b1;
            end
            OP_MOVR: begin
                // load data comes back from the memory, registered beside the result
                o_exec.mem_addr = addr_sum & DM_MASK;
                o_exec.is_load  = 1'b1;
                o_exec.wr       = 1'b1;
            end
            OP_MOVM: begin
                o_exec.mem_addr  = addr_sum & DM_MASK;
                o_exec.store_val = i_r1_val;
                o_exec.is_store  = 1'b1;
            end
            default: begin
            end
        endcase

        // drop writes to register zero or past the file
        if (!reg_ok(r1)) begin
            o_exec.wr = 1'b0;
        end
        if (o_exec.wr) begin
            o_exec.idx = r1;
        end else begin
            o_exec.val = '0;
        end
    end

endmodule

@@ rtl/custom_isa_execute_unit.sv @@
// ----------------------------------------------------------------------------
// custom_isa_execute_unit: in-order execute unit for a small custom ISA
// Register file, data memory and program counter with full forwarding.
// ----------------------------------------------------------------------------
// Words pass stage 1, then the stage 2 result register. Throughput: one
// instruction per cycle while result ready is high; loads and stores too.
// The single data memory port (one read or one write per cycle) and the
// registered register-file reads set the two-stage structure.
// Reset: synchronous, active low; clears PC and register file at once, then
// zeroes all DATA_DEPTH (2048) data memory words in turn, input ready low.
// ----------------------------------------------------------------------------
module custom_isa_execute_unit import cie_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cie_instr_if.sink     i_instr,
    cie_result_if.source  o_result
);

    // ------------------------------------------------------------------
    // Pipeline control
    // Stage 1 holds the accepted word and its registered operand reads.
    // Stage 2 is the result register; it also writes the register file.
    // ------------------------------------------------------------------
    logic               r_s1_valid;
    logic [WORD_W-1:0]  r_s1_word;
    logic               r_s2_valid;
    t_exec_out          r_s2;
    logic [WORD_W-1:0]  r_pc;
    logic               r_clr_busy;
    logic [DM_AW-1:0]   r_clr_idx;

    logic               s2_free;
    logic               s1_go;
    logic               in_ready;
    logic               accept;

    assign s2_free  = !r_s2_valid || o_result.ready;
    assign s1_go    = r_s1_valid && s2_free;
    assign in_ready = !r_clr_busy && (!r_s1_valid || s2_free);
    assign accept   = i_instr.valid && in_ready;

    assign i_instr.ready = in_ready;

    // ------------------------------------------------------------------
    // Register file: two copies give three read ports, both written from
    // stage 2. Valid bits make never-written entries read as zero.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]    r_rf_a [REG_COUNT];
    logic [WORD_W-1:0]    r_rf_b [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;

    logic [WORD_W-1:0]    r_ld_data;
    logic                 wb_en;
    logic [WORD_W-1:0]    wb_val;

    assign wb_en  = r_s2_valid && r_s2.wr;
    assign wb_val = r_s2.is_load ? r_ld_data : r_s2.val;

    logic [FIELD_W-1:0] in_f1, in_f2, in_f3;
    assign in_f1 = i_instr.instruction_word[27:23];
    assign in_f2 = i_instr.instruction_word[22:18];
    assign in_f3 = i_instr.instruction_word[17:13];

    logic [WORD_W-1:0] r_q1, r_q2, r_q3;

    // write back every cycle stage 2 holds a write; repeats are harmless
    always_ff @(posedge i_clk) begin
        if (wb_en) begin
            r_rf_a[r_s2.idx[REG_IDX_W-1:0]] <= wb_val;
            r_rf_b[r_s2.idx[REG_IDX_W-1:0]] <= wb_val;
        end
        if (accept) begin
            r_q1 <= r_rf_a[in_f1[REG_IDX_W-1:0]];
            r_q2 <= r_rf_a[in_f2[REG_IDX_W-1:0]];
            r_q3 <= r_rf_b[in_f3[REG_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (wb_en) begin
            r_rf_vld[r_s2.idx[REG_IDX_W-1:0]] <= 1'b1;
        end
    end

    // Capture-time bypass: the write landing on the same edge as the read
    // is not in the read data, so record it beside the read.
    logic [2:0]        r_byp;
    logic [2:0]        r_zero;
    logic [WORD_W-1:0] r_byp_val;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp_val <= wb_val;
            r_byp[0]  <= wb_en && (r_s2.idx == in_f1);
            r_byp[1]  <= wb_en && (r_s2.idx == in_f2);
            r_byp[2]  <= wb_en && (r_s2.idx == in_f3);
            r_zero[0] <= !reg_ok(in_f1) || !r_rf_vld[in_f1[REG_IDX_W-1:0]];
            r_zero[1] <= !reg_ok(in_f2) || !r_rf_vld[in_f2[REG_IDX_W-1:0]];
            r_zero[2] <= !reg_ok(in_f3) || !r_rf_vld[in_f3[REG_IDX_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Operand select in stage 1: forward from stage 2 first, then the
    // capture bypass, then zero for invalid entries, then the registered read.
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0] s1_f1, s1_f2, s1_f3;
    logic [WORD_W-1:0]  op1, op2, op3;

    assign s1_f1 = r_s1_word[27:23];
    assign s1_f2 = r_s1_word[22:18];
    assign s1_f3 = r_s1_word[17:13];

    assign op1 = (wb_en && r_s2.idx == s1_f1) ? wb_val :
                 r_byp[0] ? r_byp_val : r_zero[0] ? '0 : r_q1;
    assign op2 = (wb_en && r_s2.idx == s1_f2) ? wb_val :
                 r_byp[1] ? r_byp_val : r_zero[1] ? '0 : r_q2;
    assign op3 = (wb_en && r_s2.idx == s1_f3) ? wb_val :
                 r_byp[2] ? r_byp_val : r_zero[2] ? '0 : r_q3;

    t_exec_out exec;

    cie_exec u_exec (
        .i_word   (r_s1_word),
        .i_r1_val (op1),
        .i_r2_val (op2),
        .i_r3_val (op3),
        .i_pc     (r_pc),
        .o_exec   (exec)
    );

    // ------------------------------------------------------------------
    // Data memory: one port. Clear sweep after reset, then stores from
    // stage 1; load data is registered into stage 2 alongside the result.
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] r_dmem [DATA_DEPTH];

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_dmem[r_clr_idx] <= '0;
        end else if (s1_go && exec.is_store) begin
            r_dmem[exec.mem_addr[DM_AW-1:0]] <= exec.store_val;
        end
        if (s1_go && exec.is_load) begin
            r_ld_data <= r_dmem[exec.mem_addr[DM_AW-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_pc       <= '0;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + DM_AW'(1);
                if (r_clr_idx == DM_AW'(DATA_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_go) begin
                r_pc <= exec.next_pc;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_word <= i_instr.instruction_word;
        end
        if (s1_go) begin
            r_s2 <= exec;
        end
    end

    // ------------------------------------------------------------------
    // Result word
    // ------------------------------------------------------------------
    assign o_result.valid        = r_s2_valid;
    assign o_result.next_pc      = r_s2.next_pc;
    assign o_result.branch_taken = r_s2.taken;
    assign o_result.reg_write    = r_s2.wr;
    assign o_result.reg_index    = r_s2.idx;
    assign o_result.reg_value    = r_s2.is_load ? (r_s2.wr ? r_ld_data : '0) : r_s2.val;
    assign o_result.mem_write    = r_s2.is_store;
    assign o_result.mem_address  = r_s2.mem_addr[ADDR_OUT_W-1:0];
    assign o_result.mem_value    = r_s2.is_load ? r_ld_data : r_s2.store_val;

endmodule
